// ----- rtl/mwc_rng_pkg.sv -----
// ----------------------------------------------------------------------------
// mwc_rng_pkg
// Shared types and constants of the lag-4 multiply-with-carry generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwc_rng_pkg;

  // Recurrence multipliers, oldest history word first
  localparam logic [31:0] MWC_A3 = 32'd2111111111;
  localparam logic [10:0] MWC_A2 = 11'd1492;
  localparam logic [10:0] MWC_A1 = 11'd1776;
  localparam logic [12:0] MWC_A0 = 13'd5115;

  // Seed expansion multiplier and warm-up length
  localparam logic [31:0] SEED_MULT    = 32'd29943829;
  localparam logic [4:0]  WARMUP_STEPS = 5'd19;

  // Seed expansion writes four history words, then the carry
  localparam logic [2:0]  SEED_CARRY_IDX = 3'd4;

  // Width of the summed small-constant products plus carry
  localparam int unsigned PART_W = 46;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // What the back end has to do with one queued item
  typedef enum logic [2:0] {
    K_RESEED = 3'd0,
    K_RAW    = 3'd1,
    K_RANGE  = 3'd2,
    K_FAIL   = 3'd3,
    K_SINGLE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] lo;
    logic [31:0] span;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_SEED  = 3'd1,
    BK_MUL   = 3'd2,
    BK_ADD   = 3'd3,
    BK_SCALE = 3'd4,
    BK_FIN   = 3'd5
  } bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/mwc_rng_front.sv -----
// ----------------------------------------------------------------------------
// mwc_rng_front
// Accept input transfers and classify them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_rng_front (
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [1:0]         in_tuser,   // opcode
  input  wire logic [63:0]        in_tdata,   // range_min, range_max
  input  wire logic               q_full,
  output logic                    q_push,
  output mwc_rng_pkg::entry_t     q_entry
);
  import mwc_rng_pkg::*;

  logic [31:0] lo;
  logic [31:0] hi;
  opcode_t     op;

  assign lo        = in_tdata[31:0];
  assign hi        = in_tdata[63:32];
  assign op        = opcode_t'(in_tuser);
  assign in_tready = ~q_full;

  always_comb begin
    q_entry.lo   = lo;
    q_entry.span = hi - lo + 32'd1;
    q_entry.kind = K_RAW;
    q_push       = 1'b0;
    unique case (op)
      OP_RESEED: begin
        q_entry.kind = K_RESEED;
        q_push       = in_tvalid & ~q_full;
      end
      OP_RAW: begin
        q_entry.kind = K_RAW;
        q_push       = in_tvalid & ~q_full;
      end
      OP_RANGE: begin
        priority if ($signed(hi) < $signed(lo)) begin
          q_entry.kind = K_FAIL;
        end else if (hi == lo) begin
          q_entry.kind = K_SINGLE;
        end else begin
          q_entry.kind = K_RANGE;
        end
        q_push = in_tvalid & ~q_full;
      end
      OP_NONE: begin
        // accept and drop
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mwc_rng_queue.sv -----
// ----------------------------------------------------------------------------
// mwc_rng_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_rng_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mwc_rng_pkg::entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     pop_valid,
  output mwc_rng_pkg::entry_t      pop_entry
);
  import mwc_rng_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwc_rng_back.sv -----
// ----------------------------------------------------------------------------
// mwc_rng_back
// Generator engine: seed expansion, recurrence steps, range scaling, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mwc_rng_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  input  wire logic                q_valid,
  input  wire mwc_rng_pkg::entry_t q_entry,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [31:0]              out_tdata,
  output logic                     out_tuser
);
  import mwc_rng_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [31:0]        seed_r;
  logic [31:0]        lag_r [4];
  logic [31:0]        lag_nxt [4];
  logic [31:0]        carry_r, carry_nxt;
  logic [31:0]        s_r, s_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               warm_r, warm_nxt;
  kind_t              kind_r, kind_nxt;
  logic [31:0]        lo_r, lo_nxt;
  logic [31:0]        span_r, span_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_val_r, out_val_nxt;
  logic               out_err_r, out_err_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] sum;
  logic [31:0] s_new;
  logic        out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_err_r;
  assign out_free   = ~out_valid_r | out_tready;

  // Shared 32x32 multiplier
  always_comb begin
    unique case (state_r)
      BK_SEED: begin
        mul_a = s_r;
        mul_b = SEED_MULT;
      end
      BK_MUL: begin
        mul_a = lag_r[3];
        mul_b = MWC_A3;
      end
      BK_SCALE: begin
        mul_a = lag_r[0];
        mul_b = span_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign s_new = mul_p[31:0] - 32'd1;
  assign sum   = prod_r + 64'(part_r);

  always_comb begin
    state_nxt     = state_r;
    for (int i = 0; i < 4; i++) begin
      lag_nxt[i] = lag_r[i];
    end
    carry_nxt     = carry_r;
    s_nxt         = s_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    warm_nxt      = warm_r;
    kind_nxt      = kind_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    part_nxt      = part_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    q_pop         = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          kind_nxt = q_entry.kind;
          lo_nxt   = q_entry.lo;
          span_nxt = q_entry.span;
          case (q_entry.kind)
            K_RESEED: begin
              s_nxt     = seed_r;
              idx_nxt   = '0;
              state_nxt = BK_SEED;
            end
            K_RAW, K_RANGE: begin
              warm_nxt  = 1'b0;
              state_nxt = BK_MUL;
            end
            K_FAIL: begin
              out_val_nxt   = '0;
              out_err_nxt   = 1'b1;
              out_valid_nxt = 1'b1;
            end
            K_SINGLE: begin
              out_val_nxt   = q_entry.lo;
              out_err_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end
      BK_SEED: begin
        s_nxt = s_new;
        if (idx_r == SEED_CARRY_IDX) begin
          carry_nxt = s_new;
          warm_nxt  = 1'b1;
          cnt_nxt   = WARMUP_STEPS;
          state_nxt = BK_MUL;
        end else begin
          lag_nxt[idx_r[1:0]] = s_new;
          idx_nxt             = idx_r + 3'd1;
        end
      end
      BK_MUL: begin
        prod_nxt  = mul_p;
        part_nxt  = PART_W'(lag_r[2]) * PART_W'(MWC_A2)
                  + PART_W'(lag_r[1]) * PART_W'(MWC_A1)
                  + PART_W'(lag_r[0]) * PART_W'(MWC_A0)
                  + PART_W'(carry_r);
        state_nxt = BK_ADD;
      end
      BK_ADD: begin
        lag_nxt[3] = lag_r[2];
        lag_nxt[2] = lag_r[1];
        lag_nxt[1] = lag_r[0];
        lag_nxt[0] = sum[31:0];
        carry_nxt  = sum[63:32];
        priority if (warm_r) begin
          cnt_nxt   = cnt_r - 5'd1;
          state_nxt = (cnt_r == 5'd1) ? BK_IDLE : BK_MUL;
        end else if (kind_r == K_RAW) begin
          out_val_nxt   = sum[31:0];
          out_err_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end else begin
          state_nxt = BK_SCALE;
        end
      end
      BK_SCALE: begin
        prod_nxt  = mul_p;
        state_nxt = BK_FIN;
      end
      BK_FIN: begin
        out_val_nxt   = prod_r[63:32] + lo_r;
        out_err_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seed_r      <= '0;
      for (int i = 0; i < 4; i++) begin
        lag_r[i] <= '0;
      end
      carry_r     <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      warm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      for (int i = 0; i < 4; i++) begin
        lag_r[i] <= lag_nxt[i];
      end
      carry_r     <= carry_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    kind_r    <= kind_nxt;
    lo_r      <= lo_nxt;
    span_r    <= span_nxt;
    prod_r    <= prod_nxt;
    part_r    <= part_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  a_seed_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SEED |-> idx_r <= SEED_CARRY_IDX)
    else $error("seed expansion index past carry slot");

  a_seed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SEED |-> !out_valid_r)
    else $error("result pending during reseed");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == BK_IDLE || $past(state_r) == BK_ADD
                          || $past(state_r) == BK_FIN)
    else $error("result raised from unexpected state");

  a_warm_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ADD && warm_r) |=> !out_valid_r)
    else $error("warm-up step produced a result");

endmodule

`default_nettype wire

// ----- rtl/mother_of_all_mwc_rng.sv -----
// ----------------------------------------------------------------------------
// mother_of_all_mwc_rng
// Lag-4 multiply-with-carry random word generator with reseed, raw and
// ranged-integer operations.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser: opcode; tdata: range_min, range_max
//  out_    | out | out_tvalid/out_tready| tdata: value; tuser: range_error
//  cfg_    | in  | cfg_we               | cfg_wdata: seed
//
//  Raw word: from queue head to result through the pop, product and sum steps.
//  Ranged integer: pop, product, sum, scale and finish; inverted or single-value range: pop only.
//  Reseed: 5 seed expansion steps plus 19 warm-up steps, each a product then a sum.
//  Reseed, raw and ranged operations share one 32x32 multiplier.
//  Reset (rst_n low, synchronous) clears history, carry, seed and the queue.
//  The queue keeps accepting input while a result waits on out_tready, until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mother_of_all_mwc_rng #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,    // seed
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,     // [1:0] opcode
  input  wire logic [63:0] in_tdata,     // [31:0] range_min, [63:32] range_max
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] value
  output logic             out_tuser     // [0] range_error
);
  import mwc_rng_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_out;

  // Classify: reseed, raw, ranged step, inverted range, single value; drop
  // the unused opcode.
  mwc_rng_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // Hold classified items so the front keeps taking transfers, until the queue is
  // full, while the engine works or the result waits.
  mwc_rng_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  // Advance the generator and drive the result register.
  mwc_rng_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
